### rtl/dual_position_pid_with_ramp_defines.svh
// Assertion macros used by the controller RTL of the dual position controller.
`ifndef DUAL_POSITION_PID_WITH_RAMP_DEFINES_SVH
`define DUAL_POSITION_PID_WITH_RAMP_DEFINES_SVH
`ifndef SYNTHESIS
`define DPPR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dppr assertion failed");
`define DPPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dppr assertion failed");
`else
`define DPPR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DPPR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/dppr_pkg.sv
// Types and constants shared by the dual position controller modules.
`timescale 1ns / 1ps
package dppr_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_POST,
    ST_RAMP,
    ST_ERR,
    ST_DRIVE,
    ST_DONE
  } state_t;

  // Products formed on the shared multiplier.
  typedef enum logic [2:0] {
    OP_ANGLE,
    OP_INTEG,
    OP_DERIV,
    OP_KP,
    OP_KI,
    OP_KD
  } op_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_KP    = 3'd0;
  localparam logic [2:0] REG_KI    = 3'd1;
  localparam logic [2:0] REG_KD    = 3'd2;
  localparam logic [2:0] REG_DPC   = 3'd3;
  localparam logic [2:0] REG_STEP  = 3'd4;
  localparam logic [2:0] REG_LIMIT = 3'd5;
  localparam logic [2:0] REG_TPER  = 3'd6;
  localparam logic [2:0] REG_TPS   = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic post;
    logic ramp;
    logic err;
    logic drive;
    logic out_load;
    logic motor;
    op_t  op;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

### rtl/dppr_mac.sv
// Shared 25 x 24 multiplier that builds a 50 x 24 product from a low-half step followed by a high-half step.
`timescale 1ns / 1ps
module dppr_mac (
  input  logic        clk,
  input  logic        lo,
  input  logic        hi,
  input  logic [49:0] a,
  input  logic [23:0] b,
  output logic [73:0] acc
);

  logic [24:0] a_part;
  logic [48:0] prod;

  // The low half of the operand goes first, the high half is added shifted.
  assign a_part = hi ? a[49:25] : a[24:0];
  assign prod   = a_part * b;

  always_ff @(posedge clk) begin
    if (lo) begin
      acc <= {25'b0, prod};
    end else if (hi) begin
      acc <= acc + {prod, 25'b0};
    end
  end

endmodule

### rtl/dppr_datapath.sv
// Datapath: configuration, motor state, arithmetic and the result register.
`timescale 1ns / 1ps
module dppr_datapath #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int GAIN_FRAC_BITS  = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  dppr_pkg::cmd_t     cmd,
  output dppr_pkg::status_t  status,
  input  logic [63:0]        in_data,
  input  logic [1:0]         in_user,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [71:0]        out_data
);

  localparam logic [73:0] POS_LIM = {26'b0, 1'b0, {46{1'b1}}, 1'b1};
  localparam logic [73:0] NEG_LIM = {26'b0, 1'b1, 46'b0, 1'b0};

  // Configuration registers.
  logic [15:0] kp, ki, kd, limit, tper;
  logic [23:0] dpc, max_step;
  logic [13:0] tps;

  // Per-motor state and the current item.
  logic [31:0]        count [2];
  logic signed [47:0] ramp [2];
  logic signed [47:0] prev [2];
  logic signed [47:0] integ [2];
  logic               first_tick;
  logic signed [15:0] tgt_in [2];
  logic               zero_in [2];

  // Working registers.
  logic signed [47:0] angle, err, d_sat;
  logic signed [48:0] s_sum, d_diff;
  logic signed [49:0] sum;
  logic [15:0]        ang_out [2];
  logic [15:0]        duty_out [2];
  logic               dir_out [2];

  logic               m;
  logic signed [49:0] opnd;
  logic               opnd_neg;
  logic [49:0]        opnd_mag;
  logic [23:0]        gain;
  logic [73:0]        acc;

  function automatic logic signed [47:0] sat_mag(input logic neg, input logic [73:0] mg);
    logic signed [47:0] r;
    if (!neg) begin
      r = (mg > POS_LIM) ? POS_LIM[47:0] : mg[47:0];
    end else begin
      r = (mg > NEG_LIM) ? NEG_LIM[47:0] : -mg[47:0];
    end
    return r;
  endfunction

  assign m = cmd.motor;

  // Operand selection and magnitude for the shared multiplier.
  always_comb begin
    unique case (cmd.op)
      dppr_pkg::OP_ANGLE: begin
        opnd = {{18{count[m][31]}}, count[m]};
        gain = dpc;
      end
      dppr_pkg::OP_INTEG: begin
        opnd = {s_sum[48], s_sum};
        gain = {8'b0, tper};
      end
      dppr_pkg::OP_DERIV: begin
        opnd = {d_diff[48], d_diff};
        gain = {10'b0, tps};
      end
      dppr_pkg::OP_KP: begin
        opnd = {{2{err[47]}}, err};
        gain = {8'b0, kp};
      end
      dppr_pkg::OP_KI: begin
        opnd = {{2{integ[m][47]}}, integ[m]};
        gain = {8'b0, ki};
      end
      dppr_pkg::OP_KD: begin
        opnd = {{2{d_sat[47]}}, d_sat};
        gain = {8'b0, kd};
      end
      default: begin
        opnd = '0;
        gain = '0;
      end
    endcase
    opnd_neg = opnd[49];
    opnd_mag = opnd_neg ? 50'(-opnd) : 50'(opnd);
  end

  dppr_mac u_mac (
    .clk (clk),
    .lo  (cmd.mul_lo),
    .hi  (cmd.mul_hi),
    .a   (opnd_mag),
    .b   (gain),
    .acc (acc)
  );

  // Post-processing of products, ramp, error and drive terms.
  logic signed [47:0] a_sat;
  logic [49:0]        i_mag;
  logic signed [50:0] i_sum;
  logic signed [47:0] i_sat;
  logic [73:0]        t_sh;
  logic signed [49:0] term;
  logic signed [47:0] tgt_q;
  logic signed [48:0] r_diff, r_lim, r_step;
  logic [47:0]        amag, w;
  logic [15:0]        rep;
  logic signed [48:0] e_diff;
  logic signed [47:0] e_sat;
  logic [49:0]        smag, q;
  logic [15:0]        duty;

  always_comb begin
    a_sat = sat_mag(opnd_neg, acc);
    i_mag = acc[65:16];
    i_sum = {{3{integ[m][47]}}, integ[m]} +
            (opnd_neg ? -$signed({1'b0, i_mag}) : $signed({1'b0, i_mag}));
    if (i_sum > 51'sh0_7FFF_FFFF_FFFF) begin
      i_sat = POS_LIM[47:0];
    end else if (i_sum < -51'sh0_8000_0000_0000) begin
      i_sat = NEG_LIM[47:0];
    end else begin
      i_sat = i_sum[47:0];
    end
    t_sh = acc >> ANGLE_FRAC_BITS;
    term = opnd_neg ? -$signed({2'b0, t_sh[47:0]}) : $signed({2'b0, t_sh[47:0]});

    tgt_q  = {{32{tgt_in[m][15]}}, tgt_in[m]} <<< ANGLE_FRAC_BITS;
    r_diff = {tgt_q[47], tgt_q} - {ramp[m][47], ramp[m]};
    r_lim  = {25'b0, max_step};
    if (r_diff > r_lim) begin
      r_step = r_lim;
    end else if (r_diff < -r_lim) begin
      r_step = -r_lim;
    end else begin
      r_step = r_diff;
    end

    amag = angle[47] ? 48'(-angle) : 48'(angle);
    w    = amag >> ANGLE_FRAC_BITS;
    if (!angle[47]) begin
      rep = (w > 48'd32767) ? 16'h7FFF : w[15:0];
    end else begin
      rep = (w > 48'd32768) ? 16'h8000 : 16'(-w[15:0]);
    end

    e_diff = {ramp[m][47], ramp[m]} - {angle[47], angle};
    if (e_diff > 49'sh0_7FFF_FFFF_FFFF) begin
      e_sat = POS_LIM[47:0];
    end else if (e_diff < -49'sh0_8000_0000_0000) begin
      e_sat = NEG_LIM[47:0];
    end else begin
      e_sat = e_diff[47:0];
    end

    smag = sum[49] ? 50'(-sum) : 50'(sum);
    q    = smag >> GAIN_FRAC_BITS;
    duty = (q > {34'b0, limit}) ? limit : q[15:0];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      kp       <= 16'd256;
      ki       <= 16'd0;
      kd       <= 16'd77;
      dpc      <= 24'd65536;
      max_step <= 24'd13107;
      limit    <= 16'd255;
      tper     <= 16'd328;
      tps      <= 14'd200;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dppr_pkg::REG_KP:    kp       <= cfg_data[15:0];
        dppr_pkg::REG_KI:    ki       <= cfg_data[15:0];
        dppr_pkg::REG_KD:    kd       <= cfg_data[15:0];
        dppr_pkg::REG_DPC:   dpc      <= cfg_data;
        dppr_pkg::REG_STEP:  max_step <= cfg_data;
        dppr_pkg::REG_LIMIT: limit    <= cfg_data[15:0];
        dppr_pkg::REG_TPER:  tper     <= cfg_data[15:0];
        dppr_pkg::REG_TPS:   tps      <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // Motor state and the per-tick sequence of updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      count[0]   <= '0;
      count[1]   <= '0;
      ramp[0]    <= '0;
      ramp[1]    <= '0;
      prev[0]    <= '0;
      prev[1]    <= '0;
      integ[0]   <= '0;
      integ[1]   <= '0;
      first_tick <= 1'b1;
    end else begin
      if (cmd.load) begin
        count[0] <= count[0] + {{16{in_data[15]}}, in_data[15:0]};
        count[1] <= count[1] - {{16{in_data[31]}}, in_data[31:16]};
      end
      if (cmd.post && cmd.op == dppr_pkg::OP_ANGLE) begin
        if (zero_in[m]) begin
          count[m] <= '0;
          ramp[m]  <= '0;
          integ[m] <= '0;
          prev[m]  <= '0;
        end else if (first_tick) begin
          ramp[m] <= a_sat;
        end
      end
      if (cmd.post && cmd.op == dppr_pkg::OP_INTEG) begin
        integ[m] <= i_sat;
      end
      if (cmd.ramp) begin
        ramp[m] <= ramp[m] + r_step[47:0];
      end
      if (cmd.err) begin
        prev[m] <= e_sat;
      end
      if (cmd.out_load) begin
        first_tick <= 1'b0;
      end
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt_in[0]  <= in_data[47:32];
      tgt_in[1]  <= in_data[63:48];
      zero_in[0] <= in_user[0];
      zero_in[1] <= in_user[1];
    end
    if (cmd.post) begin
      unique case (cmd.op)
        dppr_pkg::OP_ANGLE: angle <= zero_in[m] ? '0 : a_sat;
        dppr_pkg::OP_INTEG: ;
        dppr_pkg::OP_DERIV: d_sat <= a_sat;
        dppr_pkg::OP_KP:    sum   <= term;
        dppr_pkg::OP_KI:    sum   <= sum + term;
        dppr_pkg::OP_KD:    sum   <= sum + term;
        default: ;
      endcase
    end
    if (cmd.ramp) begin
      ang_out[m] <= rep;
    end
    if (cmd.err) begin
      err    <= e_sat;
      s_sum  <= {e_sat[47], e_sat} + {prev[m][47], prev[m]};
      d_diff <= {e_sat[47], e_sat} - {prev[m][47], prev[m]};
    end
    if (cmd.drive) begin
      duty_out[m] <= duty;
      dir_out[m]  <= !sum[49] && (q != '0) && (limit != '0);
    end
  end

  // Result register: holds an item until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {6'b0, duty_out[1], dir_out[1], duty_out[0], dir_out[0],
                   ang_out[1], ang_out[0]};
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

### rtl/dppr_ctrl.sv
// Controller: sequences the two motors' work on the shared datapath.
`timescale 1ns / 1ps
`include "dual_position_pid_with_ramp_defines.svh"
module dppr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dppr_pkg::status_t status,
  output dppr_pkg::cmd_t    cmd
);

  dppr_pkg::state_t state, state_next;
  dppr_pkg::op_t    op, op_next;
  logic             motor, motor_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dppr_pkg::ST_IDLE;
      op    <= dppr_pkg::OP_ANGLE;
      motor <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      motor <= motor_next;
    end
  end

  // Next state: angle, ramp, error, then the five products and drive, per motor.
  always_comb begin
    state_next = state;
    op_next    = op;
    motor_next = motor;
    unique case (state)
      dppr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = dppr_pkg::ST_MUL_LO;
          op_next    = dppr_pkg::OP_ANGLE;
          motor_next = 1'b0;
        end
      end
      dppr_pkg::ST_MUL_LO: state_next = dppr_pkg::ST_MUL_HI;
      dppr_pkg::ST_MUL_HI: state_next = dppr_pkg::ST_POST;
      dppr_pkg::ST_POST: begin
        unique case (op)
          dppr_pkg::OP_ANGLE: state_next = dppr_pkg::ST_RAMP;
          dppr_pkg::OP_INTEG: begin
            state_next = dppr_pkg::ST_MUL_LO;
            op_next    = dppr_pkg::OP_DERIV;
          end
          dppr_pkg::OP_DERIV: begin
            state_next = dppr_pkg::ST_MUL_LO;
            op_next    = dppr_pkg::OP_KP;
          end
          dppr_pkg::OP_KP: begin
            state_next = dppr_pkg::ST_MUL_LO;
            op_next    = dppr_pkg::OP_KI;
          end
          dppr_pkg::OP_KI: begin
            state_next = dppr_pkg::ST_MUL_LO;
            op_next    = dppr_pkg::OP_KD;
          end
          dppr_pkg::OP_KD: state_next = dppr_pkg::ST_DRIVE;
          default: ;
        endcase
      end
      dppr_pkg::ST_RAMP: state_next = dppr_pkg::ST_ERR;
      dppr_pkg::ST_ERR: begin
        state_next = dppr_pkg::ST_MUL_LO;
        op_next    = dppr_pkg::OP_INTEG;
      end
      dppr_pkg::ST_DRIVE: begin
        if (!motor) begin
          state_next = dppr_pkg::ST_MUL_LO;
          op_next    = dppr_pkg::OP_ANGLE;
          motor_next = 1'b1;
        end else begin
          state_next = dppr_pkg::ST_DONE;
        end
      end
      dppr_pkg::ST_DONE: begin
        if (status.out_free) begin
          state_next = dppr_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    in_ready     = (state == dppr_pkg::ST_IDLE);
    cmd.load     = (state == dppr_pkg::ST_IDLE) && in_valid;
    cmd.mul_lo   = (state == dppr_pkg::ST_MUL_LO);
    cmd.mul_hi   = (state == dppr_pkg::ST_MUL_HI);
    cmd.post     = (state == dppr_pkg::ST_POST);
    cmd.ramp     = (state == dppr_pkg::ST_RAMP);
    cmd.err      = (state == dppr_pkg::ST_ERR);
    cmd.drive    = (state == dppr_pkg::ST_DRIVE);
    cmd.out_load = (state == dppr_pkg::ST_DONE) && status.out_free;
    cmd.motor    = motor;
    cmd.op       = op;
  end

  `DPPR_ASSERT_NEXT(a_lo_then_hi, clk, rst, state == dppr_pkg::ST_MUL_LO, state == dppr_pkg::ST_MUL_HI)
  `DPPR_ASSERT_NEXT(a_accept_starts, clk, rst, cmd.load, state == dppr_pkg::ST_MUL_LO && op == dppr_pkg::OP_ANGLE && !motor)
  `DPPR_ASSERT_IMPL(a_done_second, clk, rst, state == dppr_pkg::ST_DONE, motor)

endmodule

### rtl/dual_position_pid_with_ramp.sv
// Top level of the two-motor position controller with ramped targets.
`timescale 1ns / 1ps
// Each input item is one control tick for motors A and B; it yields exactly one
// result item with the reported angles, directions and duties. All twelve
// products of a tick (angle, integral step, derivative and three gain terms, for
// each motor) run on one shared 25 x 24 multiplier, each as a low-half step, a
// high-half step and a post-processing step; each motor also has a ramp, an error
// and a drive step, and a final step loads the result register. The block takes
// no new item until the previous result has been loaded into the output register;
// it takes one as soon as that is done, even while that result still waits for
// the sink. Configuration writes are always accepted.
module dual_position_pid_with_ramp #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int GAIN_FRAC_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // delta_count_a, delta_count_b, target_a, target_b
  input  logic [63:0] s_axis_tdata,
  // zero_a, zero_b
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // angle_a, angle_b, dir_a, duty_a, dir_b, duty_b, zero padding
  output logic [71:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  dppr_pkg::cmd_t    cmd;
  dppr_pkg::status_t status;

  assign cfg_ready = 1'b1;

  dppr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dppr_datapath #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .GAIN_FRAC_BITS  (GAIN_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
